// ----- design/explicit_diffusion_reaction_row_step_unit_macros.svh -----
// Assertion macros used by the row step unit top level.
`ifndef EXPLICIT_DIFFUSION_REACTION_ROW_STEP_UNIT_MACROS_SVH
`define EXPLICIT_DIFFUSION_REACTION_ROW_STEP_UNIT_MACROS_SVH
`ifndef SYNTH
`define EDRS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle implication failed");
`define EDRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle implication failed");
`else
`define EDRS_ASSERT_IMP(label, ante, cons)
`define EDRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/edrs_pkg.sv -----
// Types, constants and the square root step of the row step unit.
package edrs_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 24;
	localparam int RATIO_BITS = 24;
	localparam int INDEX_BITS = 2;

	localparam int DIFF_W     = WORD_BITS + 2;
	localparam int ACC_W      = 2 * WORD_BITS + 2;
	localparam int Q_W        = ACC_W - FRAC_BITS;
	localparam int ROOT_W     = ((WORD_BITS + FRAC_BITS + 3) / 4) * 2;
	localparam int RAD_W      = 2 * ROOT_W;
	localparam int REM_W      = ROOT_W + 2;
	localparam int ROOT_STEPS = ROOT_W / 2;
	localparam int CNT_W      = $clog2(ROOT_STEPS);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [INDEX_BITS-1:0] REG_DIFFUSION_RATIO = INDEX_BITS'(0);
	localparam logic [INDEX_BITS-1:0] REG_LINEAR_GAIN     = INDEX_BITS'(1);
	localparam logic [INDEX_BITS-1:0] REG_ROOT_GAIN       = INDEX_BITS'(2);

	localparam logic [RATIO_BITS-1:0]       RATIO_RESET = RATIO_BITS'(8388608);
	localparam logic signed [WORD_BITS-1:0] LINEAR_RESET = WORD_BITS'(20972);
	localparam logic signed [WORD_BITS-1:0] ROOT_RESET   = -WORD_BITS'(20972);

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef struct packed {
		logic [RATIO_BITS-1:0]       diffusion_ratio;
		logic signed [WORD_BITS-1:0] linear_gain;
		logic signed [WORD_BITS-1:0] root_gain;
	} cfg_t;

	// One queue entry holds every result that one accepted point causes.
	typedef struct packed {
		logic                        has_int;
		logic                        has_bnd;
		logic                        last;
		logic signed [WORD_BITS-1:0] left;
		logic signed [WORD_BITS-1:0] centre;
		logic signed [WORD_BITS-1:0] right;
		logic signed [WORD_BITS-1:0] fixed;
	} entry_t;

	typedef struct packed {
		logic   valid;
		logic   full;
		entry_t head;
	} queue_st_t;

	typedef struct packed {
		logic idle;
		logic pop;
	} back_st_t;

	typedef enum logic [1:0] {
		POS_EMPTY = 2'd0,
		POS_FIRST = 2'd1,
		POS_INNER = 2'd2
	} pos_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROOT,
		BK_MUL,
		BK_ADD,
		BK_FINAL,
		BK_EMIT_INT,
		BK_EMIT_BND
	} back_state_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} root_step_t;

	// One digit of the restoring square root: bring in two radicand bits,
	// try to subtract 4*root+1 and shift the outcome into the root.
	function automatic root_step_t sqrt_step(input logic [REM_W-1:0] rem,
		input logic [ROOT_W-1:0] root, input logic [1:0] bits);
		logic [REM_W+1:0] rem_sh;
		logic [REM_W+1:0] trial;
		root_step_t       res;
		rem_sh = {rem, bits};
		trial  = {2'b00, root, 2'b01};
		if (rem_sh >= trial) begin
			res.rem  = REM_W'(rem_sh - trial);
			res.root = {root[ROOT_W-2:0], 1'b1};
		end else begin
			res.rem  = rem_sh[REM_W-1:0];
			res.root = {root[ROOT_W-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

// ----- design/edrs_front.sv -----
// Front part: keeps the three-point window and turns each point into a queue entry.
module edrs_front
	import edrs_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] point_value,
	input  logic signed [WORD_BITS-1:0] fixed_next_value,
	input  logic                        first_of_row,
	input  logic                        last_of_row,
	input  logic                        queue_full,
	output logic                        push,
	output entry_t                      entry
);

	logic signed [WORD_BITS-1:0] left_q;
	logic signed [WORD_BITS-1:0] centre_q;
	pos_t                        pos_q;
	logic                        accept;
	logic                        start_row;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// A point with no row open, or with first set, opens a new row.
	always_comb begin
		case (pos_q)
			POS_FIRST, POS_INNER: start_row = first_of_row;
			default:              start_row = 1'b1;
		endcase
	end

	always_comb begin
		entry.has_int = !start_row && (pos_q == POS_INNER);
		entry.has_bnd = start_row || last_of_row;
		entry.last    = last_of_row;
		entry.left    = left_q;
		entry.centre  = centre_q;
		entry.right   = point_value;
		entry.fixed   = fixed_next_value;
	end

	assign push = accept && (entry.has_int || entry.has_bnd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			centre_q <= '0;
			pos_q    <= POS_EMPTY;
		end else if (accept) begin
			centre_q <= point_value;
			if (start_row) begin
				left_q <= '0;
				pos_q  <= last_of_row ? POS_EMPTY : POS_FIRST;
			end else begin
				left_q <= centre_q;
				pos_q  <= last_of_row ? POS_EMPTY : POS_INNER;
			end
		end
	end

endmodule

// ----- design/edrs_queue.sv -----
// Short queue of entries between the front and the back part.
module edrs_queue
	import edrs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_entry,
	input  logic      pop,
	output queue_st_t st
);

	entry_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign st.valid = (count_q != '0);
	assign st.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign st.head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/edrs_back.sv -----
// Back part: computes interior points, forwards boundary values, holds the output register.
module edrs_back
	import edrs_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfg_t                        cfg,
	input  queue_st_t                   qst,
	output back_st_t                    st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] next_value,
	output logic                        row_done,
	output logic                        negative_root,
	output logic                        saturated
);

	back_state_t                 state_q;
	back_state_t                 state_d;
	entry_t                      job_q;
	logic signed [DIFF_W-1:0]    diff_q;
	logic [RAD_W-1:0]            radicand_q;
	logic [REM_W-1:0]            rem_q;
	logic [ROOT_W-1:0]           root_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic signed [ACC_W-1:0]     prod_s_q;
	logic signed [ACC_W-1:0]     prod_a_q;
	logic signed [ACC_W-1:0]     prod_b_q;
	logic signed [ACC_W-1:0]     sum1_q;
	logic signed [ACC_W-1:0]     sum2_q;
	logic signed [WORD_BITS-1:0] res_q;
	logic                        sat_q;

	logic                        out_valid_q;
	logic signed [WORD_BITS-1:0] out_value_q;
	logic                        out_last_q;
	logic                        out_neg_q;
	logic                        out_sat_q;

	logic                        out_free;
	logic                        load_out;
	logic signed [WORD_BITS-1:0] load_value;
	logic                        load_last;
	logic                        load_neg;
	logic                        load_sat;
	root_step_t                  step1;
	root_step_t                  step2;
	logic signed [DIFF_W-1:0]    diff_new;
	logic signed [ACC_W-1:0]     acc;
	logic signed [Q_W-1:0]       quot;
	logic                        fits;
	logic signed [WORD_BITS-1:0] clipped;

	assign out_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (qst.valid) begin
					state_d = qst.head.has_int ? BK_ROOT : BK_EMIT_BND;
				end
			end
			BK_ROOT: begin
				if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL:   state_d = BK_ADD;
			BK_ADD:   state_d = BK_FINAL;
			BK_FINAL: state_d = BK_EMIT_INT;
			BK_EMIT_INT: begin
				if (out_free) begin
					state_d = job_q.has_bnd ? BK_EMIT_BND : BK_IDLE;
				end
			end
			BK_EMIT_BND: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		st.idle    = (state_q == BK_IDLE);
		st.pop     = 1'b0;
		load_out   = 1'b0;
		load_value = res_q;
		load_last  = 1'b0;
		load_neg   = neg_q;
		load_sat   = sat_q;
		case (state_q)
			BK_IDLE: st.pop = qst.valid;
			BK_EMIT_INT: load_out = out_free;
			BK_EMIT_BND: begin
				load_out   = out_free;
				load_value = job_q.fixed;
				load_last  = job_q.last;
				load_neg   = 1'b0;
				load_sat   = 1'b0;
			end
			default: load_out = 1'b0;
		endcase
	end

	always_comb begin
		step1    = sqrt_step(rem_q, root_q, radicand_q[RAD_W-1 -: 2]);
		step2    = sqrt_step(step1.rem, step1.root, radicand_q[RAD_W-3 -: 2]);
		diff_new = DIFF_W'(qst.head.left) - (DIFF_W'(qst.head.centre) <<< 1)
			+ DIFF_W'(qst.head.right);
		acc      = sum1_q + sum2_q;
		quot     = acc[ACC_W-1:FRAC_BITS];
		// The quotient fits the word when all bits above it copy its sign.
		fits     = (&quot[Q_W-1:WORD_BITS-1]) || !(|quot[Q_W-1:WORD_BITS-1]);
		clipped  = fits ? quot[WORD_BITS-1:0] : (quot[Q_W-1] ? WORD_MIN : WORD_MAX);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				job_q  <= qst.head;
				diff_q <= diff_new;
				neg_q  <= qst.head.centre[WORD_BITS-1];
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
				if (qst.head.centre[WORD_BITS-1]) begin
					radicand_q <= '0;
				end else begin
					radicand_q <= RAD_W'({qst.head.centre, {FRAC_BITS{1'b0}}});
				end
			end
			BK_ROOT: begin
				rem_q      <= step2.rem;
				root_q     <= step2.root;
				radicand_q <= radicand_q << 4;
				cnt_q      <= cnt_q + 1'b1;
			end
			BK_MUL: begin
				prod_s_q <= ACC_W'(diff_q) * ACC_W'($signed({1'b0, cfg.diffusion_ratio}));
				prod_a_q <= ACC_W'(cfg.linear_gain) * ACC_W'(job_q.centre);
				prod_b_q <= ACC_W'(cfg.root_gain) * ACC_W'($signed({1'b0, root_q}));
			end
			BK_ADD: begin
				sum1_q <= prod_s_q + prod_a_q;
				sum2_q <= prod_b_q + (ACC_W'(job_q.centre) <<< FRAC_BITS) + ROUND_HALF;
			end
			BK_FINAL: begin
				res_q <= clipped;
				sat_q <= !fits;
			end
			default: res_q <= res_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_value_q <= load_value;
			out_last_q  <= load_last;
			out_neg_q   <= load_neg;
			out_sat_q   <= load_sat;
		end
	end

	assign out_valid     = out_valid_q;
	assign next_value    = out_value_q;
	assign row_done      = out_last_q;
	assign negative_root = out_neg_q;
	assign saturated     = out_sat_q;

endmodule

// ----- design/explicit_diffusion_reaction_row_step_unit.sv -----
// Top level of the explicit diffusion-reaction row step unit.
// Usage: the points of one time-layer row enter on the s_axis channel, one
// transaction each, in row order; tuser marks the first point and tlast the
// last. The next-layer row leaves on the m_axis channel in the same order,
// with tlast on the last point's result. Registers are written on the cfg
// channel (index 0 diffusion ratio, 1 linear gain, 2 root gain), which is
// always ready; write them only while the unit is idle.
// A front part keeps the three-point window and queues up to four points'
// work; a back part computes interior points and forwards boundary values.
// An interior point passes through the back-part states in order: taking the
// entry from the queue, the square root, which resolves two root bits per
// cycle, the multiply, the add and rounding, the clipping, and the load of
// the output register. A boundary result needs only the taking of the entry
// and the load; a further entry is taken only once the back part is idle again.
// When the receiver stalls, the result holds in the output register, the
// back part waits, and the input stays ready until the queue fills.
// Reset clears the window, the queue, the output and the registers to their
// default values.
`include "explicit_diffusion_reaction_row_step_unit_macros.svh"

module explicit_diffusion_reaction_row_step_unit
	import edrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [2*WORD_BITS-1:0] s_axis_tdata,  // point_value, fixed_next_value
	input  logic                  s_axis_tlast,
	input  logic                  s_axis_tuser,  // first_of_row
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [WORD_BITS-1:0]  m_axis_tdata,  // next_value
	output logic                  m_axis_tlast,
	output logic [1:0]            m_axis_tuser,  // negative_root, saturated
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [INDEX_BITS-1:0] cfg_index,
	input  logic [WORD_BITS-1:0]  cfg_data
);

	cfg_t                        cfg_q;
	queue_st_t                   qst;
	back_st_t                    back_st;
	logic                        q_push;
	entry_t                      q_entry;
	logic signed [WORD_BITS-1:0] out_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diffusion_ratio <= RATIO_RESET;
			cfg_q.linear_gain     <= LINEAR_RESET;
			cfg_q.root_gain       <= ROOT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIFFUSION_RATIO: cfg_q.diffusion_ratio <= cfg_data[RATIO_BITS-1:0];
				REG_LINEAR_GAIN:     cfg_q.linear_gain     <= cfg_data;
				REG_ROOT_GAIN:       cfg_q.root_gain       <= cfg_data;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	edrs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.point_value      (s_axis_tdata[WORD_BITS-1:0]),
		.fixed_next_value (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
		.first_of_row     (s_axis_tuser),
		.last_of_row      (s_axis_tlast),
		.queue_full       (qst.full),
		.push             (q_push),
		.entry            (q_entry)
	);

	edrs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (back_st.pop),
		.st         (qst)
	);

	edrs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.qst           (qst),
		.st            (back_st),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.next_value    (out_value),
		.row_done      (m_axis_tlast),
		.negative_root (m_axis_tuser[0]),
		.saturated     (m_axis_tuser[1])
	);

	assign m_axis_tdata = out_value;

	// A result that closes a row is a boundary result and never carries the interior flags.
	`EDRS_ASSERT_IMP(a_bnd_no_flags, m_axis_tvalid && m_axis_tlast, m_axis_tuser == 2'b00)
	// The back part only takes work from the queue while it is idle and work is there.
	`EDRS_ASSERT_IMP(a_pop_when_idle, back_st.pop, back_st.idle && qst.valid)
	// A full queue never takes another entry.
	`EDRS_ASSERT_IMP(a_no_overflow, qst.full, !q_push)
	// Taking work moves the back part out of idle.
	`EDRS_ASSERT_NEXT(a_pop_leaves_idle, back_st.pop, !back_st.idle)

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the explicit diffusion-reaction row step unit.
`timescale 1ns / 100ps

module tb_top
	import edrs_pkg::*;
();

	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_WAIT  = 100;
	localparam int MAX_PRINTS   = 100;

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t next_value;
		logic  row_done;
		logic  negative_root;
		logic  saturated;
	} next_pt_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [2*WORD_BITS-1:0] s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [WORD_BITS-1:0]   m_axis_tdata;
	logic                   m_axis_tlast;
	logic [1:0]             m_axis_tuser;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [INDEX_BITS-1:0]  cfg_index;
	logic [WORD_BITS-1:0]   cfg_data;

	// Predictor copy of the registers and of the three-point window.
	logic [RATIO_BITS-1:0] ratio_cfg;
	word_t                 lin_cfg;
	word_t                 root_cfg;
	word_t                 left_held;
	word_t                 centre_held;
	pos_t                  row_pos;

	next_pt_t expected_next_q[$];
	next_pt_t head_want;

	int  error_count;
	int  cycle_count;
	int  points_sent;
	bit  tx_gaps;
	bit  rx_gaps;
	int  rx_hold_cycles;

	explicit_diffusion_reaction_row_step_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
		input logic [WORD_BITS-1:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
	endtask

	// Largest r with r*r <= n; n stays below 2^55, so r fits 28 bits.
	function automatic longint floor_root(input longint n);
		longint res;
		longint cand;
		res = 0;
		for (int i = 29; i >= 0; i--) begin
			cand = res | (longint'(1) << i);
			if (cand * cand <= n)
				res = cand;
		end
		return res;
	endfunction

	// Next-layer value of an interior point from its left, centre and right.
	function automatic next_pt_t stencil_value(input word_t l, input word_t u, input word_t r);
		longint   sl, su, sr, s, a, b, root, acc, q;
		next_pt_t res;
		sl   = l;
		su   = u;
		sr   = r;
		s    = longint'(ratio_cfg);
		a    = lin_cfg;
		b    = root_cfg;
		res  = '0;
		root = 0;
		if (su < 0)
			res.negative_root = 1'b1;
		else
			root = floor_root(su * (longint'(1) <<< FRAC_BITS));
		acc = s * (sl - 2 * su + sr) + a * su + b * root + su * (longint'(1) <<< FRAC_BITS);
		acc = acc + (longint'(1) <<< (FRAC_BITS - 1));
		q   = acc >>> FRAC_BITS;
		if (q > longint'(WORD_MAX)) begin
			q = WORD_MAX;
			res.saturated = 1'b1;
		end
		if (q < longint'(WORD_MIN)) begin
			q = WORD_MIN;
			res.saturated = 1'b1;
		end
		res.next_value = q[WORD_BITS-1:0];
		return res;
	endfunction

	// Moves the window by one accepted point and queues the results it releases.
	task automatic advance_window(input word_t pv, input word_t fv, input bit first,
		input bit last);
		next_pt_t bnd;
		bnd            = '0;
		bnd.next_value = fv;
		if (first || !(row_pos inside {POS_FIRST, POS_INNER})) begin
			bnd.row_done = last;
			expected_next_q.push_back(bnd);
			left_held   = '0;
			centre_held = pv;
			row_pos     = last ? POS_EMPTY : POS_FIRST;
		end else begin
			if (row_pos == POS_INNER)
				expected_next_q.push_back(stencil_value(left_held, centre_held, pv));
			left_held   = centre_held;
			centre_held = pv;
			if (last) begin
				bnd.row_done = 1'b1;
				expected_next_q.push_back(bnd);
				row_pos = POS_EMPTY;
			end else begin
				row_pos = POS_INNER;
			end
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction,
	// leaving tvalid high so that a following point can go out without a gap.
	task automatic send_point(input word_t pv, input word_t fv, input bit first,
		input bit last);
		int gap;
		gap = tx_gaps ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {fv, pv};
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		advance_window(pv, fv, first, last);
		points_sent++;
		@(negedge clk);
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return word_t'($urandom_range(0, 32'h0400_0000)) - word_t'(32'h0200_0000);
			2: return $urandom_range(0, 1) ? WORD_MAX - word_t'($urandom_range(0, 255))
				: WORD_MIN + word_t'($urandom_range(0, 255));
			3: return word_t'($urandom_range(0, 32'h1000_0000));
			default: return -word_t'($urandom_range(0, 32'h1000_0000));
		endcase
	endfunction

	// A row of len points; about half the rows carry a smooth profile that starts non-negative.
	task automatic send_row(input int len, input bit closed);
		bit    smooth;
		word_t base;
		smooth = $urandom_range(0, 1);
		base   = word_t'($urandom_range(0, 32'h0A00_0000));
		for (int i = 0; i < len; i++) begin
			if (smooth)
				base = base + word_t'($urandom_range(0, 32'h0040_0000)) - word_t'(32'h0020_0000);
			send_point(smooth ? base : rand_word(), rand_word(), i == 0,
				closed && (i == len - 1));
		end
	endtask

	// Lowers tvalid and waits until every expected result has left the block.
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_next_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic load_gains(input logic [RATIO_BITS-1:0] ratio, input word_t lin,
		input word_t rg);
		logic [WORD_BITS-1:0]  data [3];
		logic [INDEX_BITS-1:0] idx [3];
		data[0] = {{(WORD_BITS - RATIO_BITS){1'b0}}, ratio};
		data[1] = lin;
		data[2] = rg;
		idx[0]  = REG_DIFFUSION_RATIO;
		idx[1]  = REG_LINEAR_GAIN;
		idx[2]  = REG_ROOT_GAIN;
		settle_idle();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= data[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				REG_DIFFUSION_RATIO: ratio_cfg = data[i][RATIO_BITS-1:0];
				REG_LINEAR_GAIN:     lin_cfg   = data[i];
				REG_ROOT_GAIN:       root_cfg  = data[i];
				default: ;
			endcase
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Runs on the reset values of the registers.
	task automatic test_directed_rows();
		// Single-point rows at the field extremes.
		send_point(WORD_MAX, WORD_MIN, 1'b1, 1'b1);
		send_point(WORD_MIN, WORD_MAX, 1'b1, 1'b1);
		// Two-point row: boundaries only.
		send_point(32'h0100_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_point(32'h0200_0000, 32'h8000_0000, 1'b0, 1'b1);
		// Five points with a negative centre and a zero centre.
		send_point(32'h0100_0000, 32'h1234_5678, 1'b1, 1'b0);
		send_point(32'h0200_0000, 32'h0000_0000, 1'b0, 1'b0);
		send_point(32'hFF80_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_point(32'h0000_0000, 32'h5555_5555, 1'b0, 1'b0);
		send_point(32'h0300_0000, 32'hAAAA_AAAA, 1'b0, 1'b1);
		// Clipping at the top and at the bottom of the range.
		send_point(WORD_MAX, 32'h0000_0001, 1'b1, 1'b0);
		send_point(WORD_MAX, 32'h0000_0002, 1'b0, 1'b0);
		send_point(WORD_MAX, 32'h0000_0003, 1'b0, 1'b1);
		send_point(WORD_MIN, 32'hFFFF_FFFE, 1'b1, 1'b0);
		send_point(WORD_MIN, 32'hFFFF_FFFD, 1'b0, 1'b0);
		send_point(WORD_MIN, 32'hFFFF_FFFC, 1'b0, 1'b1);
		// An unfinished row: the pending interior point is dropped by the next start.
		send_point(32'h0100_0000, 32'h0F0F_0F0F, 1'b1, 1'b0);
		send_point(32'h0180_0000, 32'hF0F0_F0F0, 1'b0, 1'b0);
		send_point(32'h0200_0000, 32'h3333_3333, 1'b0, 1'b0);
		send_point(32'h0400_0000, 32'hCCCC_CCCC, 1'b1, 1'b0);
		send_point(32'h0500_0000, 32'h0101_0101, 1'b0, 1'b1);
		// Points that arrive with no open row start one.
		send_point(32'h0040_0000, 32'h7777_7777, 1'b0, 1'b0);
		send_point(32'h0080_0000, 32'h8888_8888, 1'b0, 1'b1);
	endtask

	task automatic test_register_extremes();
		logic [RATIO_BITS-1:0] ratios [5];
		word_t                 lins [5];
		word_t                 roots [5];
		ratios = '{24'h00_0000, 24'hFF_FFFF, 24'hFF_FFFF, 24'h00_0000, 24'h80_0000};
		lins   = '{32'h0000_0000, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX};
		roots  = '{32'h0000_0000, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN};
		for (int k = 0; k < 5; k++) begin
			load_gains(ratios[k], lins[k], roots[k]);
			send_row(1, 1'b1);
			send_row(2, 1'b1);
			send_row($urandom_range(3, 10), 1'b1);
			send_row($urandom_range(3, 10), 1'b1);
		end
	endtask

	// Mostly well-formed rows under random settings, with broken rows mixed in.
	task automatic test_random_rows();
		int phase_end;
		int pick;
		for (int ph = 0; ph < 12; ph++) begin
			if ($urandom_range(0, 1))
				load_gains(RATIO_BITS'($urandom_range(0, 24'h80_0000)),
					word_t'($urandom_range(0, 32'h0020_0000)) - word_t'(32'h0010_0000),
					word_t'($urandom_range(0, 32'h0020_0000)) - word_t'(32'h0010_0000));
			else
				load_gains(RATIO_BITS'($urandom_range(0, 24'hFF_FFFF)), $urandom, $urandom);
			phase_end = points_sent + 140;
			while (points_sent < phase_end) begin
				pick = $urandom_range(0, 9);
				if (pick < 8)
					send_row($urandom_range(0, 3) == 0 ? $urandom_range(1, 3)
						: $urandom_range(3, 12), 1'b1);
				else if (pick == 8)
					send_row($urandom_range(1, 6), 1'b0);
				else
					repeat ($urandom_range(1, 3))
						send_point(rand_word(), rand_word(), 1'b0,
							1'($urandom_range(0, 1)));
			end
		end
	endtask

	// The receiver stops for a long stretch while points keep coming.
	task automatic test_backpressure();
		load_gains(24'h40_0000, 32'h0001_0000, 32'hFFFF_0000);
		tx_gaps        = 1'b0;
		rx_hold_cycles = 300;
		repeat (6)
			send_row($urandom_range(6, 12), 1'b1);
		tx_gaps = 1'b1;
	endtask

	task automatic test_back_to_back();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		repeat (8)
			send_row($urandom_range(1, 16), 1'b1);
		settle_idle();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	// Result receiver: random stalls per result, plus a long hold on request.
	initial begin
		while (arst_n !== 1'b1)
			@(negedge clk);
		@(negedge clk);
		forever begin
			int wait_n;
			wait_n = rx_gaps ? $urandom_range(0, 5) : 0;
			if (rx_hold_cycles > 0) begin
				wait_n         = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (wait_n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// Every result transaction is checked against the oldest expected point.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_next_q.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, '0);
			end else begin
				head_want = expected_next_q.pop_front();
				if (m_axis_tdata !== head_want.next_value)
					report_mismatch("next_value", m_axis_tdata, head_want.next_value);
				if (m_axis_tlast !== head_want.row_done)
					report_mismatch("row_done", WORD_BITS'(m_axis_tlast),
						WORD_BITS'(head_want.row_done));
				if (m_axis_tuser[0] !== head_want.negative_root)
					report_mismatch("negative_root", WORD_BITS'(m_axis_tuser[0]),
						WORD_BITS'(head_want.negative_root));
				if (m_axis_tuser[1] !== head_want.saturated)
					report_mismatch("saturated", WORD_BITS'(m_axis_tuser[1]),
						WORD_BITS'(head_want.saturated));
			end
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tlast   = 1'b0;
		s_axis_tuser   = 1'b0;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_DIFFUSION_RATIO;
		cfg_data       = '0;
		error_count    = 0;
		cycle_count    = 0;
		points_sent    = 0;
		tx_gaps        = 1'b1;
		rx_gaps        = 1'b1;
		rx_hold_cycles = 0;
		ratio_cfg      = RATIO_RESET;
		lin_cfg        = LINEAR_RESET;
		root_cfg       = ROOT_RESET;
		left_held      = '0;
		centre_held    = '0;
		row_pos        = POS_EMPTY;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_rows();
		test_register_extremes();
		test_random_rows();
		test_backpressure();
		test_back_to_back();
		settle_idle();

		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/edrs_pkg.sv
design/edrs_front.sv
design/edrs_queue.sv
design/edrs_back.sv
design/explicit_diffusion_reaction_row_step_unit.sv
verif/tb_top.sv
